FILE: src/icst_pkg.sv
package icst_pkg;

  // Image side limit used for the default accumulator sizing
  localparam int MAX_SIDE_DEF = 1024;

  // Channel layout: red, green, blue, alpha
  localparam int NUM_CH   = 4;
  localparam int CH_ALPHA = 3;
  localparam int MEAN_W   = 8;
  localparam int STEP_W   = $clog2(MEAN_W);

  localparam logic [MEAN_W-1:0] FULL_ALPHA = 8'hFF;
  localparam logic [MEAN_W-1:0] ZERO_ALPHA = 8'h00;

  // Stream widths
  localparam int IN_TDATA_W  = NUM_CH * MEAN_W;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IN_TDATA_W - 2;

  typedef logic [MEAN_W-1:0] chan_t;

  // Controller states
  typedef enum logic [2:0] {
    S_ACCUM = 3'b001,
    S_DIV   = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic acc;       // pixel request accepted
    logic load_div;  // last pixel accepted: capture totals, clear sums
    logic step;      // one quotient bit for every channel
    logic load_out;  // move quotients into the output register
  } icst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_last; // the current division step is the final one
  } icst_sts_t;

endpackage

FILE: src/icst_ctrl.sv
module icst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output icst_pkg::icst_cmd_t cmd,
  input  icst_pkg::icst_sts_t sts
);

  icst_pkg::state_t state;
  icst_pkg::state_t state_next;

  // Output register may be loaded when empty or drained this cycle
  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      icst_pkg::S_ACCUM: begin
        in_ready = 1'b1;
        cmd.acc  = in_valid;
        if (in_valid && in_last) begin
          cmd.load_div = 1'b1;
          state_next   = icst_pkg::S_DIV;
        end
      end
      icst_pkg::S_DIV: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_next = icst_pkg::S_WAIT;
        end
      end
      icst_pkg::S_WAIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = icst_pkg::S_ACCUM;
        end
      end
      default: begin
        state_next = icst_pkg::S_ACCUM;
      end
    endcase
  end

  // State and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= icst_pkg::S_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Never overwrite a result that is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten while pending");

  // Pixels are only taken while accumulating
  a_acc_state: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> (state == icst_pkg::S_ACCUM))
    else $error("pixel accepted outside accumulate state");

  // End of frame always starts the divider
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load_div |=> (state == icst_pkg::S_DIV))
    else $error("divider not started after last pixel");

  // Final division step hands over to the output stage
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == icst_pkg::S_DIV && sts.step_last) |=> (state == icst_pkg::S_WAIT))
    else $error("division did not finish after final step");

endmodule

FILE: src/icst_dp.sv
module icst_dp #(
  parameter int MAX_SIDE = icst_pkg::MAX_SIDE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic                                  cfg_wdata,
  input  icst_pkg::chan_t [icst_pkg::NUM_CH-1:0] pix,
  input  icst_pkg::icst_cmd_t                   cmd,
  output icst_pkg::icst_sts_t                   sts,
  output icst_pkg::chan_t [icst_pkg::NUM_CH-1:0] mean,
  output logic                                  is_translucent,
  output logic                                  is_all_opaque
);

  // Counts hold up to MAX_SIDE^2 pixels; sums are MEAN_W - 1 bits wider, and both saturate
  localparam int CNT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SUM_W = CNT_W + icst_pkg::MEAN_W - 1;

  logic alpha_present;

  // Accumulators
  logic [SUM_W-1:0] sum      [icst_pkg::NUM_CH];
  logic [SUM_W-1:0] sum_next [icst_pkg::NUM_CH];
  logic [CNT_W-1:0] pix_cnt, opq_cnt, trn_cnt;
  logic [CNT_W-1:0] pix_cnt_next, opq_cnt_next, trn_cnt_next;
  logic             pix_opq, pix_trn;

  // Divider
  logic [SUM_W-1:0]            rem [icst_pkg::NUM_CH];
  icst_pkg::chan_t             quo [icst_pkg::NUM_CH];
  logic [SUM_W-1:0]            dsh;
  logic [icst_pkg::STEP_W-1:0] step_cnt;
  logic                        alpha_used, trn_flag, opq_flag;

  // Saturating adds for one pixel
  logic [SUM_W:0] sum_ext [icst_pkg::NUM_CH];
  logic [CNT_W:0] pix_ext, opq_ext, trn_ext;

  assign pix_opq = (pix[icst_pkg::CH_ALPHA] == icst_pkg::FULL_ALPHA);
  assign pix_trn = !pix_opq && (pix[icst_pkg::CH_ALPHA] != icst_pkg::ZERO_ALPHA);

  always_comb begin
    for (int c = 0; c < icst_pkg::NUM_CH; c++) begin
      sum_ext[c]  = {1'b0, sum[c]} + (SUM_W + 1)'(pix[c]);
      sum_next[c] = sum_ext[c][SUM_W] ? '1 : sum_ext[c][SUM_W-1:0];
    end
    pix_ext      = {1'b0, pix_cnt} + (CNT_W + 1)'(1);
    opq_ext      = {1'b0, opq_cnt} + (CNT_W + 1)'(pix_opq);
    trn_ext      = {1'b0, trn_cnt} + (CNT_W + 1)'(pix_trn);
    pix_cnt_next = pix_ext[CNT_W] ? '1 : pix_ext[CNT_W-1:0];
    opq_cnt_next = opq_ext[CNT_W] ? '1 : opq_ext[CNT_W-1:0];
    trn_cnt_next = trn_ext[CNT_W] ? '1 : trn_ext[CNT_W-1:0];
  end

  // Config register and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_present <= 1'b1;
      for (int c = 0; c < icst_pkg::NUM_CH; c++) begin
        sum[c] <= '0;
      end
      pix_cnt <= '0;
      opq_cnt <= '0;
      trn_cnt <= '0;
    end else begin
      if (cfg_wen) begin
        alpha_present <= cfg_wdata;
      end
      if (cmd.load_div) begin
        for (int c = 0; c < icst_pkg::NUM_CH; c++) begin
          sum[c] <= '0;
        end
        pix_cnt <= '0;
        opq_cnt <= '0;
        trn_cnt <= '0;
      end else if (cmd.acc) begin
        for (int c = 0; c < icst_pkg::NUM_CH; c++) begin
          sum[c] <= sum_next[c];
        end
        pix_cnt <= pix_cnt_next;
        opq_cnt <= opq_cnt_next;
        trn_cnt <= trn_cnt_next;
      end
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load_div) begin
      step_cnt <= icst_pkg::STEP_W'(icst_pkg::MEAN_W - 1);
    end else if (cmd.step) begin
      step_cnt <= step_cnt - icst_pkg::STEP_W'(1);
    end
  end

  assign sts.step_last = (step_cnt == '0);

  // Restoring division, one quotient bit per cycle, four lanes share the divisor
  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      for (int c = 0; c < icst_pkg::NUM_CH; c++) begin
        rem[c] <= sum_next[c];
        quo[c] <= '0;
      end
      dsh        <= {pix_cnt_next, {(icst_pkg::MEAN_W - 1){1'b0}}};
      alpha_used <= alpha_present;
      trn_flag   <= (trn_cnt_next >= (pix_cnt_next >> 1));
      opq_flag   <= (opq_cnt_next == pix_cnt_next);
    end else if (cmd.step) begin
      for (int c = 0; c < icst_pkg::NUM_CH; c++) begin
        if (rem[c] >= dsh) begin
          rem[c] <= rem[c] - dsh;
          quo[c] <= {quo[c][icst_pkg::MEAN_W-2:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][icst_pkg::MEAN_W-2:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
    end
  end

  // Output register; alpha results fixed when alpha is ignored
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int c = 0; c < icst_pkg::NUM_CH; c++) begin
        if (c == icst_pkg::CH_ALPHA && !alpha_used) begin
          mean[c] <= icst_pkg::FULL_ALPHA;
        end else begin
          mean[c] <= quo[c];
        end
      end
      is_translucent <= alpha_used && trn_flag;
      is_all_opaque  <= !alpha_used || opq_flag;
    end
  end

endmodule

FILE: src/image_color_stats_translucency.sv
// Result: once the last pixel of a frame is accepted, the block runs
//   8 restoring-division steps, then one output load; the load waits while the
//   previous result is still held. Throughput: one pixel per cycle within a frame;
//   after a frame end, pixels wait for the 8 quotient steps and the output load.
// Reset (rst, synchronous): sums and counts cleared, alpha_present set to 1,
//   no result pending.
module image_color_stats_translucency #(
  parameter int MAX_SIDE = icst_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic                             cfg_wdata,   // alpha_present
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_red, pixel_green, pixel_blue, pixel_alpha
  input  logic [icst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tlast,  // frame_last
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // mean_red, mean_green, mean_blue, mean_alpha, is_translucent, is_all_opaque, zero pad
  output logic [icst_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  icst_pkg::icst_cmd_t                    cmd;
  icst_pkg::icst_sts_t                    sts;
  icst_pkg::chan_t [icst_pkg::NUM_CH-1:0] pix;
  icst_pkg::chan_t [icst_pkg::NUM_CH-1:0] mean;
  logic                                   is_translucent, is_all_opaque;

  assign pix = s_axis_tdata;

  icst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  icst_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .pix            (pix),
    .cmd            (cmd),
    .sts            (sts),
    .mean           (mean),
    .is_translucent (is_translucent),
    .is_all_opaque  (is_all_opaque)
  );

  assign m_axis_tdata = {{icst_pkg::OUT_PAD_W{1'b0}}, is_all_opaque, is_translucent, mean};

endmodule
